FILE: rtl/oaht_pkg.sv
// types and constants shared by the open address hash table modules
// no dependencies
package oaht_pkg;

   localparam int SLOT_W = 7;
   localparam int COUNT_W = 7;
   localparam int KEY_LO_W = 64;
   localparam int KEY_HI_W = 56;
   localparam int LEN_W = 4;

   localparam logic [1:0] FUNC_SEARCH   = 2'd0;
   localparam logic [1:0] FUNC_ADD      = 2'd1;
   localparam logic [1:0] FUNC_DELETE   = 2'd2;
   localparam logic [1:0] FUNC_RESERVED = 2'd3;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_PRESENT  = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [1:0] MARK_EMPTY   = 2'd0;
   localparam logic [1:0] MARK_USED    = 2'd1;
   localparam logic [1:0] MARK_DELETED = 2'd2;

   typedef struct packed {
      logic [1:0]          func;
      logic [KEY_LO_W-1:0] key_bytes_low;
      logic [KEY_HI_W-1:0] key_bytes_high;
      logic [LEN_W-1:0]    key_length;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [SLOT_W-1:0]  slot_index;
      logic [COUNT_W-1:0] live_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, clear hash state
      logic hash_step;  // accumulate one key byte
      logic hash_done;  // reduce sum to home slot, probe 0
      logic probe_rd;   // issue read of current probe slot
      logic probe_next; // advance probe index
      logic probe_rst;  // restart probe path at home slot
      logic note_found; // remember current slot as match
      logic write_used; // write key and used mark to current slot
      logic write_del;  // mark found slot deleted
      logic respond;    // present the result
      logic [1:0] status;
      logic use_found;  // slot_index from match register
      logic use_probe;  // slot_index from current probe slot
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       hash_last;
      logic       probe_last;
      logic [1:0] mark;
      logic       key_match;
      logic [1:0] func;
   } stat_type;

endpackage

FILE: rtl/open_address_hash_table_top.sv
// Open-addressed hash set of up to 101 keys of 0 to 15 bytes, quadratic probing.
// After reset the block runs a clearing pass over the slot marks with busy high.
// An item is taken when start is high and busy low; its result appears on rsp_*
// for one cycle with rsp_strobe, the cycle in which busy drops. After the accept
// edge an item hashes its key one byte at a time and reduces the sum to the home
// slot; each probe of the search reads the slot memory, then compares. A found key
// takes one more state, and an add that misses runs an insert scan that reads and
// compares each probe in the same way; the strobe is registered after the last
// state. The worst case is an add of a 15-byte key that runs both 20-probe scans.
// The receiver cannot stall.
module open_address_hash_table_top import oaht_pkg::*; #(
   parameter int TABLE_SLOTS   = 101,
   parameter int MAX_KEY_BYTES = 15,
   parameter int MAX_PROBES    = 20
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   cmd_type  cmd;
   stat_type stat;
   logic clr_en;
   logic [SLOT_W-1:0] clr_addr;

   oaht_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
      .clock, .reset, .start, .busy, .stat, .cmd, .clr_en, .clr_addr
   );

   oaht_datapath #(
      .TABLE_SLOTS(TABLE_SLOTS), .MAX_KEY_BYTES(MAX_KEY_BYTES),
      .MAX_PROBES(MAX_PROBES)
   ) u_dp (
      .clock, .reset, .req_in(req_payload), .cmd, .clr_en, .clr_addr, .stat,
      .rsp_strobe, .rsp_payload
   );

   a_no_strobe_idle_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe) else $error("result strobe right after accept");
   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("busy while result shown");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_payload.slot_index < SLOT_W'(TABLE_SLOTS))
      else $error("slot index out of range");

endmodule

FILE: rtl/oaht_datapath.sv
// hash unit, probe sequencer, slot memories and live counter
// depends on oaht_pkg
module oaht_datapath import oaht_pkg::*; #(
   parameter int TABLE_SLOTS   = 101,
   parameter int MAX_KEY_BYTES = 15,
   parameter int MAX_PROBES    = 20
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_in,
   input  cmd_type  cmd,
   input  logic     clr_en,
   input  logic [SLOT_W-1:0] clr_addr,
   output stat_type stat,
   output logic     rsp_strobe,
   output rsp_type  rsp_payload
);

   localparam int PJ_W = $clog2(MAX_PROBES + 1);
   localparam int BI_W = 4;
   localparam int SUM_W = 18;
   localparam int RECIP_SH = 27;
   localparam longint RECIP_19 = ((longint'(19) << RECIP_SH) + longint'(TABLE_SLOTS) - 1)
                                 / longint'(TABLE_SLOTS);

   logic [1:0]          mark_mem [TABLE_SLOTS];
   logic [KEY_LO_W-1:0] klo_mem  [TABLE_SLOTS];
   logic [KEY_HI_W-1:0] khi_mem  [TABLE_SLOTS];
   logic [LEN_W-1:0]    len_mem  [TABLE_SLOTS];

   logic [1:0]          func_ff;
   logic [KEY_LO_W-1:0] klo_ff, klo_in;
   logic [KEY_HI_W-1:0] khi_ff, khi_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [BI_W-1:0]     bi_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SLOT_W-1:0]   h0_ff, slot_ff, found_ff;
   logic [PJ_W-1:0]     pj_ff;
   logic [SLOT_W-1:0]   step_ff; // (j*j + 23j) mod slots, incremental
   logic [SLOT_W-1:0]   delta_ff; // (2j + 24) mod slots
   logic [1:0]          rd_mark_ff;
   logic [KEY_LO_W-1:0] rd_klo_ff;
   logic [KEY_HI_W-1:0] rd_khi_ff;
   logic [LEN_W-1:0]    rd_len_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                strobe_ff;
   rsp_type             rsp_ff;

   logic [7:0]  cur_byte;
   logic [SUM_W+4:0] sum19, hrem;
   logic [39:0] hprod;
   logic [12:0] hquo;
   logic [SLOT_W-1:0] h0_calc, step_nx, delta_nx;
   logic [LEN_W-1:0] eff_len;

   function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
      logic [SLOT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (SLOT_W+1)'(TABLE_SLOTS)) s = s - (SLOT_W+1)'(TABLE_SLOTS);
      return s[SLOT_W-1:0];
   endfunction

   // mask off invalid key bytes at capture
   always_comb begin
      eff_len = (req_in.key_length > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES)
                                                             : req_in.key_length;
      klo_in = req_in.key_bytes_low;
      khi_in = req_in.key_bytes_high;
      for (int i = 0; i < 8; i++)
         if (LEN_W'(i) >= eff_len) klo_in[i*8 +: 8] = 8'd0;
      for (int i = 0; i < 7; i++)
         if (LEN_W'(i + 8) >= eff_len) khi_in[i*8 +: 8] = 8'd0;
      len_in = eff_len;
   end

   // home slot = 19*sum mod slots: quotient by reciprocal multiply, then subtract
   always_comb begin
      if (bi_ff < BI_W'(8)) cur_byte = klo_ff[bi_ff[2:0]*8 +: 8];
      else                  cur_byte = khi_ff[(bi_ff[2:0])*8 +: 8];
      sum19 = (SUM_W+5)'(sum_ff) * (SUM_W+5)'(19);
      hprod = 40'(sum_ff) * 40'(RECIP_19);
      hquo = hprod[RECIP_SH +: 13];
      hrem = sum19 - (SUM_W+5)'(hquo) * (SUM_W+5)'(TABLE_SLOTS);
      h0_calc = hrem[SLOT_W-1:0];
      step_nx = add_mod(step_ff, delta_ff);
      delta_nx = add_mod(delta_ff, SLOT_W'(2));
   end

   // weighted sum stays below 2^15
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_in.func;
         klo_ff <= klo_in;
         khi_ff <= khi_in;
         len_ff <= len_in;
         bi_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.hash_step) begin
         sum_ff <= sum_ff + SUM_W'(cur_byte) * SUM_W'({1'b0, bi_ff} + 5'd1);
         bi_ff <= bi_ff + BI_W'(1);
      end
      if (cmd.hash_done) begin
         h0_ff <= h0_calc;
         slot_ff <= h0_calc;
      end
      if (cmd.hash_done || cmd.probe_rst) begin
         pj_ff <= '0;
         step_ff <= '0;
         delta_ff <= SLOT_W'(24);
         if (cmd.probe_rst) slot_ff <= h0_ff;
      end else if (cmd.probe_next) begin
         pj_ff <= pj_ff + PJ_W'(1);
         step_ff <= step_nx;
         delta_ff <= delta_nx;
         slot_ff <= add_mod(h0_ff, step_nx);
      end
      if (cmd.note_found) found_ff <= slot_ff;
   end

   // slot memories
   always_ff @(posedge clock) begin
      if (clr_en) mark_mem[clr_addr] <= MARK_EMPTY;
      else if (cmd.write_used) mark_mem[slot_ff] <= MARK_USED;
      else if (cmd.write_del) mark_mem[found_ff] <= MARK_DELETED;
      if (cmd.write_used) begin
         klo_mem[slot_ff] <= klo_ff;
         khi_mem[slot_ff] <= khi_ff;
         len_mem[slot_ff] <= len_ff;
      end
      if (cmd.probe_rd) begin
         rd_mark_ff <= mark_mem[slot_ff];
         rd_klo_ff <= klo_mem[slot_ff];
         rd_khi_ff <= khi_mem[slot_ff];
         rd_len_ff <= len_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (cmd.write_used) count_ff <= count_ff + COUNT_W'(1);
         else if (cmd.write_del && count_ff != '0) count_ff <= count_ff - COUNT_W'(1);
         strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.status <= cmd.status;
         rsp_ff.slot_index <= cmd.use_found ? found_ff :
                              cmd.use_probe ? slot_ff : '0;
         rsp_ff.live_count <= cmd.write_used ? count_ff + COUNT_W'(1) :
                              (cmd.write_del && count_ff != '0) ? count_ff - COUNT_W'(1)
                                                                : count_ff;
      end
   end

   assign stat.hash_last = bi_ff >= len_ff;
   assign stat.probe_last = pj_ff == PJ_W'(MAX_PROBES - 1);
   assign stat.mark = rd_mark_ff;
   assign stat.key_match = (rd_klo_ff == klo_ff) && (rd_khi_ff == khi_ff) &&
                           (rd_len_ff == len_ff);
   assign stat.func = func_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/oaht_ctrl.sv
// controller state machine for the hash table: clear pass, hash, search, insert
// depends on oaht_pkg
module oaht_ctrl import oaht_pkg::*; #(
   parameter int TABLE_SLOTS = 101
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     clr_en,
   output logic [SLOT_W-1:0] clr_addr
);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_HASH  = 8'b0000_0100,
      S_SRD   = 8'b0000_1000,
      S_SCHK  = 8'b0001_0000,
      S_IRD   = 8'b0010_0000,
      S_ICHK  = 8'b0100_0000,
      S_HOLD  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cmd = '0;
      clr_en = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            clr_en = 1'b1;
            clr_in = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(TABLE_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (stat.hash_last) begin
               cmd.hash_done = 1'b1;
               state_in = S_SRD;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         S_SRD: begin
            cmd.probe_rd = 1'b1;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (stat.mark == MARK_USED && stat.key_match) begin
               cmd.note_found = 1'b1;
               state_in = S_HOLD;
            end else if (stat.mark == MARK_EMPTY || stat.probe_last) begin
               if (stat.func == FUNC_ADD) begin
                  cmd.probe_rst = 1'b1;
                  state_in = S_IRD;
               end else begin
                  cmd.respond = 1'b1;
                  cmd.status = ST_NOTFOUND;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.probe_next = 1'b1;
               state_in = S_SRD;
            end
         end
         S_HOLD: begin
            // match latched; finish the operation
            cmd.respond = 1'b1;
            cmd.use_found = 1'b1;
            if (stat.func == FUNC_ADD) cmd.status = ST_PRESENT;
            else begin
               cmd.status = ST_DONE;
               cmd.write_del = stat.func == FUNC_DELETE;
            end
            state_in = S_IDLE;
         end
         S_IRD: begin
            cmd.probe_rd = 1'b1;
            state_in = S_ICHK;
         end
         S_ICHK: begin
            if (stat.mark != MARK_USED) begin
               cmd.write_used = 1'b1;
               cmd.respond = 1'b1;
               cmd.use_probe = 1'b1;
               cmd.status = ST_DONE;
               state_in = S_IDLE;
            end else if (stat.probe_last) begin
               cmd.respond = 1'b1;
               cmd.status = ST_FULL;
               state_in = S_IDLE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in = S_IRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
   end

   assign busy = state_ff != S_IDLE;
   assign clr_addr = clr_ff;

endmodule

FILE: verif/open_address_hash_table_top_tb.sv
// testbench for the open address hash table: directed and random search/add/delete items
// depends on oaht_pkg and open_address_hash_table_top
module open_address_hash_table_top_tb import oaht_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 101;
   localparam int PROBES = 20;
   localparam int STALL_LIMIT = 5000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_payload;
   logic rsp_strobe;
   rsp_type rsp_payload;

   open_address_hash_table_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
   );

   // predicted table contents
   logic [1:0] tbl_mark [SLOTS];
   logic [KEY_LO_W-1:0] tbl_lo [SLOTS];
   logic [KEY_HI_W-1:0] tbl_hi [SLOTS];
   logic [LEN_W-1:0] tbl_len [SLOTS];
   int unsigned tbl_count;

   rsp_type pending_rsp[$];
   int unsigned errors;
   int unsigned items_sent;
   int unsigned rsps_seen;
   int unsigned idle_cycles;
   int unsigned n_full, n_present, n_notfound;
   bit timed_out;

   // small pool of keys so that adds, hits and deletes collide often
   req_type key_pool[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch on %s: got %0d expected %0d (result %0d)", what, got, want, rsps_seen);
   endtask

   function automatic int unsigned home_of(input req_type r);
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < r.key_length && i < 15; i++) begin
         if (i < 8) sum += r.key_bytes_low[8*i +: 8] * (i + 1);
         else sum += r.key_bytes_high[8*(i-8) +: 8] * (i + 1);
      end
      return (19 * sum) % SLOTS;
   endfunction

   // keep only the valid key bytes
   function automatic req_type trim_key(input req_type r);
      req_type t;
      t = r;
      for (int i = 0; i < 15; i++) begin
         if (i >= r.key_length) begin
            if (i < 8) t.key_bytes_low[8*i +: 8] = 8'h00;
            else t.key_bytes_high[8*(i-8) +: 8] = 8'h00;
         end
      end
      return t;
   endfunction

   function automatic rsp_type hash_table_step(input req_type r);
      req_type k;
      rsp_type o;
      int unsigned h0, s;
      int found;
      k = trim_key(r);
      h0 = home_of(k);
      found = -1;
      for (int j = 0; j < PROBES; j++) begin
         s = (h0 + j*j + 23*j) % SLOTS;
         if (tbl_mark[s] == MARK_EMPTY) break;
         if (tbl_mark[s] == MARK_USED && tbl_len[s] == k.key_length &&
             tbl_lo[s] == k.key_bytes_low && tbl_hi[s] == k.key_bytes_high) begin
            found = s;
            break;
         end
      end
      o = '0;
      if (k.func == FUNC_ADD) begin
         if (found >= 0) begin
            o.status = ST_PRESENT;
            o.slot_index = SLOT_W'(found);
         end else begin
            o.status = ST_FULL;
            for (int j = 0; j < PROBES; j++) begin
               s = (h0 + j*j + 23*j) % SLOTS;
               if (tbl_mark[s] != MARK_USED) begin
                  tbl_mark[s] = MARK_USED;
                  tbl_lo[s] = k.key_bytes_low;
                  tbl_hi[s] = k.key_bytes_high;
                  tbl_len[s] = k.key_length;
                  tbl_count++;
                  o.status = ST_DONE;
                  o.slot_index = SLOT_W'(s);
                  break;
               end
            end
         end
      end else if (k.func == FUNC_DELETE) begin
         if (found >= 0) begin
            o.slot_index = SLOT_W'(found);
            tbl_mark[found] = MARK_DELETED;
            if (tbl_count > 0) tbl_count--;
         end else begin
            o.status = ST_NOTFOUND;
         end
      end else begin
         if (found >= 0) o.slot_index = SLOT_W'(found);
         else o.status = ST_NOTFOUND;
      end
      o.live_count = COUNT_W'(tbl_count);
      return o;
   endfunction

   // start stays high from one item to the next when no idle cycles are drawn
   task automatic send_item(input req_type r);
      int gap;
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
         start <= 1'b0;
         req_payload <= '{func: 2'($urandom), key_bytes_low: {$urandom, $urandom},
                          key_bytes_high: {$urandom, $urandom}, key_length: 4'($urandom)};
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(hash_table_step(r));
      items_sent++;
   endtask

   function automatic req_type random_key(input logic [1:0] f);
      req_type r;
      r.func = f;
      r.key_bytes_low = {$urandom, $urandom};
      r.key_bytes_high = {$urandom, $urandom};
      // mostly short keys, a few of every length
      r.key_length = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15))
                                                  : 4'($urandom_range(1, 3));
      return r;
   endfunction

   function automatic req_type make_key(input logic [1:0] f, input logic [63:0] lo,
                                        input logic [55:0] hi, input logic [3:0] len);
      req_type r;
      r.func = f;
      r.key_bytes_low = lo;
      r.key_bytes_high = hi;
      r.key_length = len;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsps_seen++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result, queue depth", 0, 1);
         end else begin
            rsp_type want;
            want = pending_rsp.pop_front();
            if (rsp_payload.status != want.status)
               report_mismatch("status", rsp_payload.status, want.status);
            if (rsp_payload.slot_index != want.slot_index)
               report_mismatch("slot_index", rsp_payload.slot_index, want.slot_index);
            if (rsp_payload.live_count != want.live_count)
               report_mismatch("live_count", rsp_payload.live_count, want.live_count);
            if (rsp_payload.status == ST_FULL) n_full++;
            if (rsp_payload.status == ST_PRESENT) n_present++;
            if (rsp_payload.status == ST_NOTFOUND) n_notfound++;
         end
      end
   end

   // watchdog on cycles with no accepted item or result
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired, %0d results outstanding", pending_rsp.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic test_directed();
      req_type r;
      send_item(make_key(FUNC_SEARCH, 64'h20, '0, 4'd1));            // space key on empty table
      send_item(make_key(FUNC_ADD, 64'h20, '0, 4'd1));
      send_item(make_key(FUNC_ADD, 64'h20, 56'hff, 4'd1));           // extra bytes ignored
      send_item(make_key(FUNC_SEARCH, 64'hab20, '0, 4'd1));
      send_item(make_key(FUNC_ADD, '1, '1, 4'd15));                  // all ones, max length
      send_item(make_key(FUNC_ADD, '0, '0, 4'd15));
      send_item(make_key(FUNC_ADD, 64'h80, '0, 4'd1));               // high byte value
      send_item(make_key(FUNC_ADD, 64'h80, '0, 4'd2));               // same bytes, longer
      send_item(make_key(FUNC_SEARCH, '1, '1, 4'd15));
      send_item(make_key(FUNC_RESERVED, '1, '1, 4'd15));             // reserved func
      send_item(make_key(FUNC_DELETE, 64'h20, '0, 4'd1));
      send_item(make_key(FUNC_DELETE, 64'h20, '0, 4'd1));            // delete absent
      send_item(make_key(FUNC_SEARCH, 64'h80, '0, 4'd2));            // passes a used slot of another key
      send_item(make_key(FUNC_ADD, 64'h20, '0, 4'd1));               // reuses deleted slot
      send_item(make_key(FUNC_ADD, 64'h0102030405060708, 56'h090a0b0c0d0e0f, 4'd8));
      send_item(make_key(FUNC_SEARCH, 64'h0102030405060708, 56'h1, 4'd8));
      send_item(make_key(FUNC_DELETE, '1, '1, 4'd15));
      send_item(make_key(FUNC_ADD, '0, '0, 4'd0));                   // empty key
      send_item(make_key(FUNC_SEARCH, '0, '0, 4'd0));
      r = make_key(FUNC_DELETE, '0, '0, 4'd0);
      send_item(r);
   endtask

   // fill one probe path with same-home keys until the add drops the key
   task automatic test_full_path();
      // two-byte key hashes to 19*(b0 + 2*b1) mod 101; hold b0 + 2*b1 at 5 mod 101
      for (int i = 0; i < 23; i++)
         send_item(make_key(FUNC_ADD, 64'(((5 - 2 * i) % 101 + 101) % 101)
                            | (64'(i) << 8), '0, 4'd2));
   endtask

   task automatic test_random(input int n);
      req_type r;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 9);
         if (key_pool.size() > 0 && pick < 6) begin
            r = key_pool[$urandom_range(0, key_pool.size() - 1)];
            r.func = (pick < 2) ? FUNC_SEARCH : (pick < 4) ? FUNC_ADD : FUNC_DELETE;
            if (pick == 5) r.func = FUNC_RESERVED;
         end else begin
            r = random_key((pick < 8) ? FUNC_ADD : 2'($urandom));
            if (key_pool.size() < 150) key_pool.push_back(r);
            else key_pool[$urandom_range(0, 149)] = r;
         end
         send_item(r);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   initial begin
      tbl_count = 0;
      for (int s = 0; s < SLOTS; s++) begin
         tbl_mark[s] = MARK_EMPTY;
         tbl_lo[s] = '0;
         tbl_hi[s] = '0;
         tbl_len[s] = '0;
      end
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_path();
      test_random(2000);
      drain();
      $display("sent %0d items, checked %0d results", items_sent, rsps_seen);
      $display("present %0d, not found %0d, no free slot %0d", n_present, n_notfound, n_full);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
